[hdl/wlvs_pkg.sv]
// ----------------------------------------------------------------------------
// wlvs_pkg
// Types and constants shared by the wear-leveled value slot modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wlvs_pkg;

	localparam logic        OP_SCAN          = 1'b0;
	localparam logic        OP_STORE         = 1'b1;
	localparam int unsigned MARK_IDX         = 7;
	localparam logic [15:0] PAIR_COUNT_RESET = 16'd512;
	localparam logic [15:0] MAX_PAIRS        = 16'd32768;
	localparam logic [15:0] MIN_PAIRS        = 16'd1;

	typedef struct packed {
		logic        operation;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [15:0] new_value;
	} req_t;

	typedef struct packed {
		logic        is_write;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [13:0] loaded_value;
		logic        value_found;
		logic        scan_complete;
		logic        last_of_run;
	} rsp_t;

	// one processed item, before it is split into result beats
	typedef struct packed {
		logic        is_write;
		logic [14:0] slot;
		logic [7:0]  data_even;
		logic [7:0]  data_odd;
		logic [13:0] loaded_value;
		logic        value_found;
		logic        scan_complete;
	} run_t;

endpackage

`default_nettype wire

[hdl/wlvs_stream_if.sv]
// ----------------------------------------------------------------------------
// wlvs_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface wlvs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/wear_leveled_value_slot.sv]
// ----------------------------------------------------------------------------
// wear_leveled_value_slot
// Keeps a 14-bit value in a rotating set of two-byte nonvolatile slots.
//
// req carries scan transactions (one stored byte pair each, in slot order
// from slot zero) and store transactions. rsp returns one report per scan
// and two byte-write transactions per store, the second with last_of_run.
// cfg writes pair_count and is always ready. The user must use it only
// while idle; the block does not enforce this. An accepted request is
// held in the input register, then its first result is loaded into the
// result register. A store is limited by the single result register,
// which issues one byte write per cycle while rsp is ready. A new request
// is accepted while a result waits to be taken.
// Reset clears the slot state, the scan position and pair_count to 512.
// When rsp is stalled the result register holds, then the input register
// fills and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wear_leveled_value_slot (
	input  wire            clk,
	input  wire            arst_n,
	wlvs_stream_if.sink    req,
	wlvs_stream_if.source  rsp,
	wlvs_stream_if.sink    cfg
);
	import wlvs_pkg::*;

	logic run_valid;
	logic run_ready;
	run_t run;

	wlvs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run)
	);

	wlvs_beat u_beat (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[hdl/wlvs_core.sv]
// ----------------------------------------------------------------------------
// wlvs_core
// Input register, slot state and the per-item update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module wlvs_core (
	input  wire              clk,
	input  wire              arst_n,
	wlvs_stream_if.sink      req,
	wlvs_stream_if.sink      cfg,
	output logic             run_valid,
	input  wire              run_ready,
	output wlvs_pkg::run_t   run
);
	import wlvs_pkg::*;

	logic        s1_valid_q;
	req_t        req_s1;
	logic        run_fire;

	logic [15:0] pair_count_q;
	logic [15:0] count_eff;

	logic        phase_known_q, phase_known_d;
	logic        phase_bit_q, phase_bit_d;
	logic [14:0] slot_q, slot_d;
	logic [14:0] scan_pos_q, scan_pos_d;
	logic        scan_ended_q, scan_ended_d;
	logic [13:0] held_value_q, held_value_d;
	logic        held_valid_q, held_valid_d;

	logic        mark_a, mark_b, pair_good;
	logic [15:0] scan_inc, slot_inc;

	assign cfg.ready = 1'b1;
	assign run_valid = s1_valid_q;
	assign run_fire  = s1_valid_q & run_ready;
	assign req.ready = ~s1_valid_q | run_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= PAIR_COUNT_RESET;
		end else if (cfg.valid) begin
			pair_count_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	always_comb begin
		if (pair_count_q == 16'd0) begin
			count_eff = MIN_PAIRS;
		end else if (pair_count_q > MAX_PAIRS) begin
			count_eff = MAX_PAIRS;
		end else begin
			count_eff = pair_count_q;
		end
	end

	always_comb begin
		mark_a    = req_s1.first_byte[MARK_IDX];
		mark_b    = req_s1.second_byte[MARK_IDX];
		pair_good = (mark_a ^ mark_b) & (~phase_known_q | (mark_a == phase_bit_q));
		scan_inc  = {1'b0, scan_pos_q} + 16'd1;
		slot_inc  = {1'b0, slot_q} + 16'd1;

		phase_known_d = phase_known_q;
		phase_bit_d   = phase_bit_q;
		slot_d        = slot_q;
		scan_pos_d    = scan_pos_q;
		scan_ended_d  = scan_ended_q;
		held_value_d  = held_value_q;
		held_valid_d  = held_valid_q;

		if (req_s1.operation == OP_SCAN) begin
			if (!scan_ended_q) begin
				if (!pair_good) begin
					scan_ended_d = 1'b1;
				end else begin
					phase_known_d = 1'b1;
					if (!phase_known_q) begin
						phase_bit_d = mark_a;
					end
					slot_d       = scan_pos_q;
					held_value_d = {req_s1.first_byte[6:0], req_s1.second_byte[6:0]};
					held_valid_d = 1'b1;
					scan_pos_d   = scan_inc[14:0];
					if (scan_inc >= count_eff) begin
						scan_ended_d = 1'b1;
					end
				end
			end
		end else begin
			scan_ended_d = 1'b1;
			held_value_d = req_s1.new_value[13:0];
			held_valid_d = 1'b1;
			if (phase_known_q) begin
				if (slot_inc >= count_eff) begin
					slot_d      = '0;
					phase_bit_d = ~phase_bit_q;
				end else begin
					slot_d = slot_inc[14:0];
				end
			end else begin
				phase_known_d = 1'b1;
				phase_bit_d   = 1'b0;
			end
		end

		run.is_write      = (req_s1.operation == OP_STORE);
		run.slot          = slot_d;
		run.data_even     = {phase_bit_d, held_value_d[13:7]};
		run.data_odd      = {~phase_bit_d, held_value_d[6:0]};
		run.loaded_value  = held_value_d;
		run.value_found   = held_valid_d;
		run.scan_complete = scan_ended_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_known_q <= 1'b0;
			phase_bit_q   <= 1'b0;
			slot_q        <= '0;
			scan_pos_q    <= '0;
			scan_ended_q  <= 1'b0;
			held_value_q  <= '0;
			held_valid_q  <= 1'b0;
		end else if (run_fire) begin
			phase_known_q <= phase_known_d;
			phase_bit_q   <= phase_bit_d;
			slot_q        <= slot_d;
			scan_pos_q    <= scan_pos_d;
			scan_ended_q  <= scan_ended_d;
			held_value_q  <= held_value_d;
			held_valid_q  <= held_valid_d;
		end
	end

endmodule

`default_nettype wire

[hdl/wlvs_beat.sv]
// ----------------------------------------------------------------------------
// wlvs_beat
// Result register; splits a store into its two byte-write transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module wlvs_beat (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   run_valid,
	output logic                  run_ready,
	input  wire wlvs_pkg::run_t   run,
	wlvs_stream_if.source         rsp
);
	import wlvs_pkg::*;

	logic valid_q;
	logic beat_q;
	run_t run_q;
	logic last_beat;

	assign last_beat = ~run_q.is_write | beat_q;
	assign run_ready = ~valid_q | (rsp.ready & last_beat);
	assign rsp.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= 1'b0;
		end else if (run_ready) begin
			valid_q <= run_valid;
			beat_q  <= 1'b0;
		end else if (rsp.ready) begin
			beat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_ready && run_valid) begin
			run_q <= run;
		end
	end

	always_comb begin
		rsp.data.is_write      = run_q.is_write;
		rsp.data.loaded_value  = run_q.loaded_value;
		rsp.data.value_found   = run_q.value_found;
		rsp.data.scan_complete = run_q.scan_complete;
		rsp.data.last_of_run   = last_beat;
		if (run_q.is_write) begin
			rsp.data.write_address = {run_q.slot, beat_q};
			rsp.data.write_data    = beat_q ? run_q.data_odd : run_q.data_even;
		end else begin
			rsp.data.write_address = '0;
			rsp.data.write_data    = '0;
		end
	end

endmodule

`default_nettype wire

[hdl/wlvs_checker.sv]
// ----------------------------------------------------------------------------
// wlvs_checker
// Port-level checks on the result channel of the value slot.
// ----------------------------------------------------------------------------
`default_nettype none

module wlvs_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   rsp_valid,
	input wire                   rsp_ready,
	input wire wlvs_pkg::rsp_t   rsp_data
);
	import wlvs_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.is_write |->
			rsp_data.last_of_run && rsp_data.write_address == 16'd0 &&
			rsp_data.write_data == 8'd0)
		else $error("scan report malformed");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.is_write |->
			rsp_data.value_found && rsp_data.scan_complete &&
			(rsp_data.write_address[0] == rsp_data.last_of_run))
		else $error("byte write inconsistent with held state");

	a_write_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp_data.is_write && !rsp_data.last_of_run |=>
			rsp_valid && rsp_data.is_write && rsp_data.last_of_run &&
			rsp_data.write_address == $past(rsp_data.write_address) + 16'd1 &&
			rsp_data.write_data[7] != $past(rsp_data.write_data[7]))
		else $error("second byte write missing or wrong");

endmodule

bind wear_leveled_value_slot wlvs_checker u_wlvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
